@@ design/olst_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants of the ordered list store.
// -----------------------------------------------------------------------------
package olst_pkg;

  localparam int unsigned DataW = 32;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    FuncFront  = 2'd0,
    FuncBack   = 2'd1,
    FuncTest   = 2'd2,
    FuncRemove = 2'd3
  } func_e;

endpackage

@@ design/ordered_list_store_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ordered_list_store_unit
// Bounded ordered list of signed 32-bit values with front insert, back append,
// membership test and removal of the first match, kept in a circular buffer.
// -----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  command  | in        | start_i, busy_o      | func_i, value_i
//  result   | out       | done_o (1-cycle)     | found_o, entry_count_o, refused_o
//
//  front insert and back append write the entry at the transfer edge, and the
//  result follows in the next cycle; busy_o stays low.
//  test and remove scan the memory one entry a cycle from the front; both stop
//  at the first match, and a remove then closes up the entries behind it,
//  the scan and the close-up of later entries sharing the single memory port pair.
//  the result strobe comes in the cycle after the last memory access, with
//  busy_o already low; results cannot be stalled.
//  reset empties the list at once; no clearing pass is needed.
// -----------------------------------------------------------------------------
module ordered_list_store_unit #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned SW = AW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic               found_o,
  output logic [CW-1:0]      entry_count_o,
  output logic               refused_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       head_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       cur_q;
  olst_pkg::data_t     value_q;
  logic                rem_q;
  logic                done_q;
  logic                found_q;
  logic                refused_q;
  logic [AW-1:0]       last_addr_q;
  logic [AW-1:0]       prev_addr_q;

  logic                accept;
  olst_pkg::func_e     func;
  logic                full;
  logic                cur_last;
  logic                match;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  olst_pkg::data_t     wr_data;
  logic                we;
  olst_pkg::data_t     rd_data;

  // logical position to memory address, wrapping once around the buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign busy_o   = (state_q != StIdle);
  assign accept   = start_i && !busy_o;
  assign func     = olst_pkg::func_e'(func_i);
  assign full     = (count_q == CW'(CAPACITY));
  assign cur_last = (cur_q == count_q - CW'(1));
  assign match    = (rd_data == value_q);
  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);

  always_comb begin
    rd_addr = head_q;
    we      = 1'b0;
    wr_addr = phys(head_q, count_q);
    wr_data = olst_pkg::data_t'(value_i);
    case (state_q)
      StIdle: begin
        rd_addr = head_q;
        if (accept && !full) begin
          if (func == olst_pkg::FuncFront) begin
            we      = 1'b1;
            wr_addr = head_dec;
          end else if (func == olst_pkg::FuncBack) begin
            we      = 1'b1;
          end
        end
      end
      StScan: begin
        rd_addr = phys(head_q, cur_q + CW'(1));
      end
      StShift: begin
        // entry just read moves one place toward the front
        rd_addr = phys(head_q, cur_q + CW'(1));
        we      = 1'b1;
        wr_addr = prev_addr_q;
        wr_data = rd_data;
      end
      default: begin
        rd_addr = head_q;
      end
    endcase
  end

  olst_ram #(
    .Depth(CAPACITY),
    .AddrW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    last_addr_q <= rd_addr;
    prev_addr_q <= last_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      count_q   <= '0;
      cur_q     <= '0;
      value_q   <= '0;
      rem_q     <= 1'b0;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      refused_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (func)
              olst_pkg::FuncFront, olst_pkg::FuncBack: begin
                done_q    <= 1'b1;
                found_q   <= 1'b0;
                refused_q <= full;
                if (!full) begin
                  count_q <= count_q + CW'(1);
                  if (func == olst_pkg::FuncFront) begin
                    head_q <= head_dec;
                  end
                end
              end
              default: begin
                if (count_q == '0) begin
                  done_q    <= 1'b1;
                  found_q   <= 1'b0;
                  refused_q <= 1'b0;
                end else begin
                  value_q <= olst_pkg::data_t'(value_i);
                  rem_q   <= (func == olst_pkg::FuncRemove);
                  cur_q   <= '0;
                  state_q <= StScan;
                end
              end
            endcase
          end
        end
        StScan: begin
          if (match) begin
            if (rem_q && !cur_last) begin
              cur_q   <= cur_q + CW'(1);
              state_q <= StShift;
            end else begin
              if (rem_q) begin
                count_q <= count_q - CW'(1);
              end
              done_q    <= 1'b1;
              found_q   <= 1'b1;
              refused_q <= 1'b0;
              state_q   <= StIdle;
            end
          end else if (cur_last) begin
            done_q    <= 1'b1;
            found_q   <= 1'b0;
            refused_q <= 1'b0;
            state_q   <= StIdle;
          end else begin
            cur_q <= cur_q + CW'(1);
          end
        end
        StShift: begin
          if (cur_last) begin
            count_q   <= count_q - CW'(1);
            done_q    <= 1'b1;
            found_q   <= 1'b1;
            refused_q <= 1'b0;
            state_q   <= StIdle;
          end else begin
            cur_q <= cur_q + CW'(1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign refused_o     = refused_q;
  assign entry_count_o = count_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && refused_o) |-> (entry_count_o == CW'(CAPACITY) && !found_o))
    else $error("refused insert without a full store");

  a_shift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (count_q >= CW'(2) && cur_q != '0))
    else $error("close-up with too few entries");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift && cur_last) |=> (done_o && found_o))
    else $error("removal did not report a match");

endmodule

@@ design/olst_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// olst_ram
// Simple dual-port entry memory, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module olst_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  olst_pkg::data_t    wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output olst_pkg::data_t    rdata_o
);

  olst_pkg::data_t mem_q [Depth];
  olst_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read during write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/ordered_list_store_unit_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ordered_list_store_unit_test
// Self-checking bench for the ordered list store: a short directed sequence of
// corner commands, then rounds of fill, churn and drain traffic over small
// value pools, sent in random bursts. Every result is checked against a
// queue-based model of the list.
// -----------------------------------------------------------------------------
module ordered_list_store_unit_test;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CountW = $clog2(Capacity + 1);
  localparam int unsigned RandomCmds = 1900;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 2 * Capacity + 8;

  typedef struct {
    olst_pkg::func_e func;
    olst_pkg::data_t value;
  } list_cmd_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] entry_count;
    logic              refused;
  } list_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        func_i;
  logic signed [31:0] value_i;
  logic              done_o;
  logic              found_o;
  logic [CountW-1:0] entry_count_o;
  logic              refused_o;

  list_cmd_t       pending_cmds[$];
  list_result_t    expected_results[$];
  olst_pkg::data_t list_q[$];
  olst_pkg::data_t value_pool[$];

  bit          cmd_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned cmds_accepted;
  int unsigned results_checked;
  int unsigned refused_seen;
  int unsigned hits_seen;
  int unsigned peak_fill;
  int unsigned full_visits;

  ordered_list_store_unit #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .entry_count_o(entry_count_o),
    .refused_o    (refused_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one command to the list model and returns its result
  function automatic list_result_t apply_list_op(olst_pkg::func_e op, olst_pkg::data_t val);
    list_result_t res;
    int           pos;
    res = '0;
    pos = -1;
    case (op)
      olst_pkg::FuncFront: begin
        if (list_q.size() >= Capacity) res.refused = 1'b1;
        else list_q = {val, list_q};
      end
      olst_pkg::FuncBack: begin
        if (list_q.size() >= Capacity) res.refused = 1'b1;
        else list_q = {list_q, val};
      end
      default: begin
        foreach (list_q[i]) begin
          if (pos < 0 && list_q[i] == val) pos = i;
        end
        if (pos >= 0) begin
          res.found = 1'b1;
          if (op == olst_pkg::FuncRemove) list_q.delete(pos);
        end
      end
    endcase
    res.entry_count = CountW'(list_q.size());
    return res;
  endfunction

  task automatic queue_cmd(olst_pkg::func_e op, olst_pkg::data_t val);
    list_cmd_t cmd;
    cmd.func = op;
    cmd.value = val;
    pending_cmds = {pending_cmds, cmd};
  endtask

  function automatic olst_pkg::data_t pick_value();
    if ($urandom_range(0, 99) < 85) begin
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    end
    return olst_pkg::data_t'($urandom);
  endfunction

  // insert, test and remove percentages shape each traffic segment
  task automatic queue_segment(int unsigned n, int unsigned ins_pct, int unsigned test_pct);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        queue_cmd($urandom_range(0, 1) ? olst_pkg::FuncBack : olst_pkg::FuncFront,
                  pick_value());
      end else if (r < ins_pct + test_pct) begin
        queue_cmd(olst_pkg::FuncTest, pick_value());
      end else begin
        queue_cmd(olst_pkg::FuncRemove, pick_value());
      end
    end
  endtask

  // driver: bursts of commands separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || cmd_taken) begin
      cmd_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        start_i <= 1'b1;
        func_i <= pending_cmds[0].func;
        value_i <= pending_cmds[0].value;
        void'(pending_cmds.pop_front());
        burst_left--;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: checks result strobes, then records the command transfer
  always @(posedge clk_i) begin
    list_result_t exp_res;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (found_o !== exp_res.found) begin
            $error("found: expected %0b, got %0b", exp_res.found, found_o);
            error_count++;
          end
          if (entry_count_o !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.entry_count, entry_count_o);
            error_count++;
          end
          if (refused_o !== exp_res.refused) begin
            $error("refused: expected %0b, got %0b", exp_res.refused, refused_o);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        exp_res = apply_list_op(olst_pkg::func_e'(func_i), olst_pkg::data_t'(value_i));
        expected_results = {expected_results, exp_res};
        cmd_taken = 1'b1;
        cmds_accepted++;
        if (exp_res.refused) refused_seen++;
        if (exp_res.found) hits_seen++;
        if (exp_res.entry_count > peak_fill) peak_fill = exp_res.entry_count;
        if (exp_res.entry_count == Capacity) full_visits++;
      end
    end
  end

  initial begin
    int unsigned pool_n;
    start_i = 1'b0;
    func_i = olst_pkg::FuncFront;
    value_i = '0;
    rst_ni = 1'b0;
    cmd_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;

    // empty list, extreme values, then duplicates
    queue_cmd(olst_pkg::FuncTest, 32'h0000_0000);
    queue_cmd(olst_pkg::FuncRemove, 32'h0000_0000);
    queue_cmd(olst_pkg::FuncFront, 32'h8000_0000);
    queue_cmd(olst_pkg::FuncBack, 32'h7fff_ffff);
    queue_cmd(olst_pkg::FuncFront, 32'hffff_ffff);
    queue_cmd(olst_pkg::FuncBack, 32'h0000_0000);
    queue_cmd(olst_pkg::FuncBack, 32'haaaa_aaaa);
    queue_cmd(olst_pkg::FuncFront, 32'h5555_5555);
    queue_cmd(olst_pkg::FuncTest, 32'h7fff_ffff);
    queue_cmd(olst_pkg::FuncTest, 32'h1234_5678);
    queue_cmd(olst_pkg::FuncRemove, 32'h8000_0000);
    queue_cmd(olst_pkg::FuncBack, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncFront, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncBack, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncRemove, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncTest, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncRemove, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncRemove, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncRemove, 32'h0000_0005);
    queue_cmd(olst_pkg::FuncRemove, 32'hffff_ffff);
    queue_cmd(olst_pkg::FuncTest, 32'hffff_ffff);
    queue_cmd(olst_pkg::FuncRemove, 32'h7fff_fffe);

    // rounds of fill past capacity, mixed churn, then drain
    while (pending_cmds.size() < RandomCmds) begin
      value_pool.delete();
      pool_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      repeat (pool_n) begin
        case ($urandom_range(0, 7))
          0: value_pool = {value_pool, 32'h8000_0000};
          1: value_pool = {value_pool, 32'h7fff_ffff};
          2: value_pool = {value_pool, 32'hffff_ffff};
          3: value_pool = {value_pool, 32'h0000_0000};
          default: value_pool = {value_pool, olst_pkg::data_t'($urandom)};
        endcase
      end
      queue_segment($urandom_range(70, 110), 85, 5);
      queue_segment($urandom_range(60, 200), 40, 25);
      queue_segment($urandom_range(70, 120), 10, 10);
    end
    // last round is cut short to keep the command count fixed
    while (pending_cmds.size() > RandomCmds) void'(pending_cmds.pop_back());

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d commands transferred, %0d results checked", cmds_accepted, results_checked);
    $display("%0d refused inserts, %0d hits, peak fill %0d, %0d results at full capacity",
             refused_seen, hits_seen, peak_fill, full_visits);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ ordered_list_store_unit.f @@
design/olst_pkg.sv
design/olst_ram.sv
design/ordered_list_store_unit.sv
sim/ordered_list_store_unit_test.sv
